[design/weighted_index_sampler_assert.svh]
// assertion macros shared by the sampler rtl
`ifndef WEIGHTED_INDEX_SAMPLER_ASSERT_SVH
`define WEIGHTED_INDEX_SAMPLER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define WIS_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("sampler assertion failed");

// condition must hold in the cycle after the trigger
`define WIS_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("sampler assertion failed");

`endif

[design/wis_pkg.sv]
// shared types and constants of the weighted index sampler
package wis_pkg;

  localparam int TOTAL_BITS  = 28;
  localparam int INDEX_BITS  = 13;
  localparam int VALUE_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int WPORT_BITS  = 16;
  localparam int REQ_BITS    = 2;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 3;
  localparam int REG_IDX_BITS = 1;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX       = {TOTAL_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0] RANGE_TOP_RESET = 32'h0001_0000;

  localparam logic [REG_IDX_BITS-1:0] REG_NORM_EN   = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_RANGE_TOP = 1'b1;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_DRAW   = 2'd2
  } req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[design/wis_ram.sv]
// generic single write, single read ram with registered read data
module wis_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/wis_div.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit 32 bits
module wis_div #(
  parameter int CW = 13
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [wis_pkg::VALUE_BITS+CW-1:0]   dividend,
  input  logic [CW-1:0]                       divisor,
  output logic [wis_pkg::VALUE_BITS-1:0]      quotient,
  output wis_pkg::div_stat_t                  stat
);

  localparam int QB = wis_pkg::VALUE_BITS;
  localparam int NB = $clog2(QB + 1);
  localparam logic [NB-1:0] STEPS = NB'(QB);
  localparam logic [NB-1:0] ONE   = NB'(1);

  logic [CW-1:0] rem_r, rem_nxt;
  logic [QB-1:0] qd_r, qd_nxt;
  logic [NB-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [CW:0]   trial;
  logic [CW:0]   diff;
  logic          ge;

  assign trial = {rem_r, qd_r[QB-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    qd_nxt   = qd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // upper bits start below the divisor, so only the low word needs steps
      rem_nxt  = dividend[QB +: CW];
      qd_nxt   = dividend[QB-1:0];
      cnt_nxt  = STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CW-1:0] : trial[CW-1:0];
      qd_nxt  = {qd_r[QB-2:0], ge};
      cnt_nxt = cnt_r - ONE;
      if (cnt_r == ONE) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    qd_r  <= qd_nxt;
  end

  assign quotient  = qd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[design/weighted_index_sampler.sv]
// weighted index sampler: running-sum table, binary search draw, serial normalise
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  in       | in_valid / in_ready    | in_req_type, in_weight, in_random_fraction
//  out      | out_valid / out_ready  | out_drawn_index, out_drawn_value, out_empty_list
//  config   | psel penable pwrite    | paddr, pwdata, prdata (pready tied high)
//
// clear and append items are handled in idle; in_ready stays high for them
// a draw keeps in_ready low from MUL through DONE, with search steps (up to 13 at 4096 points)
// normalising adds a serial divide after the 32x13 multiply
// an empty list draw keeps in_ready low only while in DONE; out_valid rises as in_ready does
// a result still held in the output register stalls a finished draw, not clear or append
// reset is synchronous: list emptied, normalise off, range top 1.0, no ram sweep
`include "weighted_index_sampler_assert.svh"

module weighted_index_sampler #(
  parameter int MAX_POINTS  = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wis_pkg::REQ_BITS-1:0]        in_req_type,
  input  logic [wis_pkg::WPORT_BITS-1:0]      in_weight,
  input  logic [wis_pkg::FRAC_BITS-1:0]       in_random_fraction,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wis_pkg::INDEX_BITS-1:0]      out_drawn_index,
  output logic [wis_pkg::VALUE_BITS-1:0]      out_drawn_value,
  output logic                                out_empty_list,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wis_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [wis_pkg::DATA_BITS-1:0]       pwdata,
  output logic [wis_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready
);

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int TB  = wis_pkg::TOTAL_BITS;
  localparam int FB  = wis_pkg::FRAC_BITS;
  localparam int VB  = wis_pkg::VALUE_BITS;
  localparam int WB  = wis_pkg::WPORT_BITS;
  localparam int PW  = VB + CW;
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_POINTS);
  localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SRCH,
    ST_CMP,
    ST_NORM,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [TB-1:0]                   total_r, total_nxt;
  logic                            norm_en_r, norm_en_nxt;
  logic [VB-1:0]                   range_top_r, range_top_nxt;
  logic [FB-1:0]                   frac_r, frac_nxt;
  logic [TB-1:0]                   thr_r, thr_nxt;
  logic [CW-1:0]                   lo_r, lo_nxt;
  logic [CW-1:0]                   hi_r, hi_nxt;
  logic [CW-1:0]                   mid_r, mid_nxt;
  logic [CW-1:0]                   res_idx_r, res_idx_nxt;
  logic [VB-1:0]                   res_val_r, res_val_nxt;
  logic                            res_empty_r, res_empty_nxt;
  logic [PW-1:0]                   prod_r, prod_nxt;
  logic                            div_start_r, div_start_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [wis_pkg::INDEX_BITS-1:0]  out_idx_r, out_idx_nxt;
  logic [VB-1:0]                   out_val_r, out_val_nxt;
  logic                            out_empty_r, out_empty_nxt;

  wis_pkg::req_t                   req;
  logic                            in_fire;
  logic                            cfg_wr;
  logic [wis_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic [WB-1:0]                   wmask;
  logic [WB-1:0]                   w_masked;
  logic [TB:0]                     sum;
  logic [TB-1:0]                   sum_sat;
  logic                            full;
  logic [CW:0]                     mid_sum;
  logic [CW-1:0]                   mid_calc;
  logic [TB+FB-1:0]                thr_prod;
  logic [PW-1:0]                   norm_prod;
  logic                            ram_we;
  logic [TB-1:0]                   ram_rdata;
  logic                            out_load;
  logic [VB-1:0]                   quotient;
  wis_pkg::div_stat_t              div_stat;
  logic                            draw_empty;
  logic                            in_search;

  assign req      = wis_pkg::req_t'(in_req_type);
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = paddr[2];
  assign pready   = 1'b1;

  always_comb begin
    for (int i = 0; i < WB; i++) begin
      wmask[i] = (i < WEIGHT_BITS);
    end
  end

  // running sum saturates so the table stays monotone
  assign w_masked = in_weight & wmask;
  assign sum      = {1'b0, total_r} + (TB+1)'(w_masked);
  assign sum_sat  = sum[TB] ? wis_pkg::TOTAL_MAX : sum[TB-1:0];
  assign full     = (count_r == COUNT_FULL);

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_calc  = mid_sum[CW:1];
  assign thr_prod  = total_r * frac_r;
  assign norm_prod = PW'(range_top_r) * PW'(res_idx_r);
  assign ram_we    = in_fire && (req == wis_pkg::REQ_APPEND) && !full;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    case (reg_idx)
      wis_pkg::REG_NORM_EN:   prdata = {{(wis_pkg::DATA_BITS-1){1'b0}}, norm_en_r};
      wis_pkg::REG_RANGE_TOP: prdata = range_top_r;
      default:                prdata = '0;
    endcase
  end

  wis_ram #(
    .WIDTH (TB),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (sum_sat),
    .raddr (mid_calc[AW-1:0]),
    .rdata (ram_rdata)
  );

  wis_div #(
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (prod_r),
    .divisor  (count_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    norm_en_nxt   = norm_en_r;
    range_top_nxt = range_top_r;
    frac_nxt      = frac_r;
    thr_nxt       = thr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_idx_nxt   = res_idx_r;
    res_val_nxt   = res_val_r;
    res_empty_nxt = res_empty_r;
    prod_nxt      = prod_r;
    div_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_empty_nxt = out_empty_r;

    if (cfg_wr) begin
      case (reg_idx)
        wis_pkg::REG_NORM_EN:   norm_en_nxt   = pwdata[0];
        wis_pkg::REG_RANGE_TOP: range_top_nxt = pwdata[VB-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (req)
            wis_pkg::REQ_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
            end
            wis_pkg::REQ_APPEND: begin
              if (!full) begin
                total_nxt = sum_sat;
                count_nxt = count_r + COUNT_ONE;
              end
            end
            wis_pkg::REQ_DRAW: begin
              if (count_r == '0) begin
                res_idx_nxt   = '0;
                res_val_nxt   = '0;
                res_empty_nxt = 1'b1;
                state_nxt     = ST_DONE;
              end else begin
                frac_nxt      = in_random_fraction;
                res_empty_nxt = 1'b0;
                state_nxt     = ST_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        thr_nxt   = thr_prod[TB+FB-1:FB];
        lo_nxt    = '0;
        hi_nxt    = count_r;
        state_nxt = ST_SRCH;
      end
      ST_SRCH: begin
        // ram read of the midpoint is issued here, compared next cycle
        if (lo_r == hi_r) begin
          res_idx_nxt = lo_r;
          state_nxt   = ST_NORM;
        end else begin
          mid_nxt   = mid_calc;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (ram_rdata < thr_r) begin
          lo_nxt = mid_r + COUNT_ONE;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_SRCH;
      end
      ST_NORM: begin
        if (norm_en_r) begin
          prod_nxt      = norm_prod;
          div_start_nxt = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          res_val_nxt = VB'({res_idx_r, {FB{1'b0}}});
          state_nxt   = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_val_nxt = quotient;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = wis_pkg::INDEX_BITS'(res_idx_r);
          out_val_nxt   = res_val_r;
          out_empty_nxt = res_empty_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      norm_en_r   <= 1'b0;
      range_top_r <= wis_pkg::RANGE_TOP_RESET;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      norm_en_r   <= norm_en_nxt;
      range_top_r <= range_top_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    frac_r      <= frac_nxt;
    thr_r       <= thr_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    res_idx_r   <= res_idx_nxt;
    res_val_r   <= res_val_nxt;
    res_empty_r <= res_empty_nxt;
    prod_r      <= prod_nxt;
    out_idx_r   <= out_idx_nxt;
    out_val_r   <= out_val_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_drawn_index = out_idx_r;
  assign out_drawn_value = out_val_r;
  assign out_empty_list  = out_empty_r;

  assign draw_empty = in_fire && (req == wis_pkg::REQ_DRAW) && (count_r == '0);
  assign in_search  = (state_r == ST_SRCH) || (state_r == ST_CMP);

  `WIS_ASSERT_NEXT(a_empty_draw, draw_empty, (state_r == ST_DONE) && res_empty_r)
  `WIS_ASSERT_NOW(a_cmp_range, state_r == ST_CMP, (lo_r <= mid_r) && (mid_r < hi_r))
  `WIS_ASSERT_NOW(a_search_bound, in_search, (lo_r <= hi_r) && (hi_r <= count_r))
  `WIS_ASSERT_NOW(a_div_owned, div_stat.done || div_stat.busy, state_r == ST_DIV)

endmodule
